[src/rsame_pkg.sv]
package rsame_pkg;

	localparam int unsigned CFG_DATA_BITS  = 32;
	localparam int unsigned CFG_INDEX_BITS = 2;
	localparam int unsigned MSG_BITS       = 32;
	localparam int unsigned RESULT_BITS    = 32;

	localparam logic [CFG_INDEX_BITS-1:0] REG_MODULUS     = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PUBLIC_EXP  = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PRIVATE_EXP = 2'd2;

	localparam logic MODE_ENCRYPT = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		OP_RED,
		OP_MUL,
		OP_SQR
	} op_t;

	typedef struct packed {
		logic en;
		logic first;
		logic bbit;
	} row_ctl_t;

	function automatic logic borrow_out(input logic t, input logic n, input logic bin);
		borrow_out = (~t & n) | (~(t ^ n) & bin);
	endfunction

endpackage

[src/rsame_in_if.sv]
interface rsame_in_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [31:0] message;

	modport source(output valid, output mode, output message, input ready);
	modport sink(input valid, input mode, input message, output ready);
endinterface

[src/rsame_out_if.sv]
interface rsame_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] result_value;

	modport source(output valid, output result_value, input ready);
	modport sink(input valid, input result_value, output ready);
endinterface

[src/rsame_cell.sv]
module rsame_cell
	import rsame_pkg::*;
(
	input  logic clk,
	input  logic en,
	input  logic acc_lo,
	input  logic ab,
	input  logic n_bit,
	input  logic n_lo,
	input  logic c_in,
	input  logic b1_in,
	input  logic b2_in,
	input  logic sel1,
	input  logic sel2,
	output logic acc,
	output logic nxt,
	output logic c_out,
	output logic b1_out,
	output logic b2_out
);

	logic acc_q;
	logic t;
	logic d1;
	logic d2;

	assign t      = acc_lo ^ ab ^ c_in;
	assign c_out  = (acc_lo & ab) | (c_in & (acc_lo ^ ab));
	assign d1     = t ^ n_bit ^ b1_in;
	assign b1_out = borrow_out(t, n_bit, b1_in);
	assign d2     = t ^ n_lo ^ b2_in;
	assign b2_out = borrow_out(t, n_lo, b2_in);
	assign nxt    = sel2 ? d2 : (sel1 ? d1 : t);
	assign acc    = acc_q;

	always_ff @(posedge clk) begin
		if (en) begin
			acc_q <= nxt;
		end
	end

endmodule

[src/rsame_row.sv]
module rsame_row
	import rsame_pkg::*;
#(
	parameter int unsigned WORD_BITS = 32
) (
	input  logic                 clk,
	input  row_ctl_t             ctl,
	input  logic [WORD_BITS-1:0] a,
	input  logic [WORD_BITS-1:0] n,
	output logic [WORD_BITS-1:0] acc_d
);

	logic [WORD_BITS-1:0] acc;
	logic [WORD_BITS-1:0] acc_in;
	logic [WORD_BITS:0]   c;
	logic [WORD_BITS:0]   b1;
	logic [WORD_BITS:0]   b2;
	logic [WORD_BITS-1:0] n_lo;
	logic                 acc_top;
	logic                 t_w;
	logic                 t_w1;
	logic                 b1_w;
	logic                 b2_w;
	logic                 b1_f;
	logic                 b2_f;
	logic                 sel1;
	logic                 sel2;

	assign acc_in = ctl.first ? '0 : acc;
	assign n_lo   = {n[WORD_BITS-2:0], 1'b0};
	assign c[0]   = 1'b0;
	assign b1[0]  = 1'b0;
	assign b2[0]  = 1'b0;

	for (genvar i = 0; i < WORD_BITS; i++) begin : g_cell
		logic lo;
		if (i == 0) begin : g_lsb
			assign lo = 1'b0;
		end else begin : g_mid
			assign lo = acc_in[i-1];
		end
		rsame_cell u_cell (
			.clk   (clk),
			.en    (ctl.en),
			.acc_lo(lo),
			.ab    (a[i] & ctl.bbit),
			.n_bit (n[i]),
			.n_lo  (n_lo[i]),
			.c_in  (c[i]),
			.b1_in (b1[i]),
			.b2_in (b2[i]),
			.sel1  (sel1),
			.sel2  (sel2),
			.acc   (acc[i]),
			.nxt   (acc_d[i]),
			.c_out (c[i+1]),
			.b1_out(b1[i+1]),
			.b2_out(b2[i+1])
		);
	end

	// two top bits of 2*acc + a, against n and 2n
	assign acc_top = acc_in[WORD_BITS-1];
	assign t_w     = acc_top ^ c[WORD_BITS];
	assign t_w1    = acc_top & c[WORD_BITS];
	assign b1_w    = borrow_out(t_w, 1'b0, b1[WORD_BITS]);
	assign b1_f    = borrow_out(t_w1, 1'b0, b1_w);
	assign b2_w    = borrow_out(t_w, n[WORD_BITS-1], b2[WORD_BITS]);
	assign b2_f    = borrow_out(t_w1, 1'b0, b2_w);
	assign sel2    = ~b2_f;
	assign sel1    = ~b1_f;

endmodule

[src/rsa_modular_exponentiation_unit.sv]
// RSA modular exponentiation, right-to-left square-and-multiply.
// Channels: data_in carries mode and message; data_out carries result_value.
// Config: cfg_we/cfg_index/cfg_data write modulus (0), public exponent (1)
// and private exponent (2); other indexes are ignored. Write only when idle.
// Each modular multiply runs MSB-first through a row of WORD_BITS bit cells,
// one operand bit per cycle. Per item: accept, reduce the message with one
// multiply, then per exponent bit a squaring plus a multiply when the bit is
// set, then load the output register.
// A modulus below two answers 0, skipping the multiplies.
// One item is worked at a time. The result sits in an output register; the
// next item is accepted while that result waits, and the finished item then
// waits for the register when the receiver stalls.
// Reset restores modulus 3233, public exponent 17, private exponent 2753
// and empties the block.
module rsa_modular_exponentiation_unit
	import rsame_pkg::*;
#(
	parameter int unsigned WORD_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	rsame_in_if.sink                  data_in,
	rsame_out_if.source               data_out,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int unsigned CNT_BITS = $clog2(WORD_BITS);
	localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);

	state_t               state_q;
	state_t               state_d;
	op_t                  op_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [CNT_BITS-1:0]  bit_q;
	logic [WORD_BITS-1:0] exp_q;
	logic [WORD_BITS-1:0] base_q;
	logic [WORD_BITS-1:0] res_q;
	logic [WORD_BITS-1:0] msg_q;
	logic [WORD_BITS-1:0] result_q;
	logic                 ovalid_q;
	logic [WORD_BITS-1:0] modulus_q;
	logic [WORD_BITS-1:0] pub_exp_q;
	logic [WORD_BITS-1:0] priv_exp_q;

	logic [WORD_BITS-1:0] op_a;
	logic [WORD_BITS-1:0] op_b;
	logic [WORD_BITS-1:0] acc_d;
	row_ctl_t             ctl;
	logic                 in_acc;
	logic                 last_step;
	logic                 small_mod;
	logic                 out_free;

	assign in_acc    = data_in.valid & data_in.ready;
	assign last_step = (cnt_q == '0);
	assign small_mod = (modulus_q[WORD_BITS-1:1] == '0);
	assign out_free  = ~ovalid_q | data_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= WORD_BITS'(32'd3233);
			pub_exp_q  <= WORD_BITS'(32'd17);
			priv_exp_q <= WORD_BITS'(32'd2753);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODULUS:     modulus_q  <= cfg_data[WORD_BITS-1:0];
				REG_PUBLIC_EXP:  pub_exp_q  <= cfg_data[WORD_BITS-1:0];
				REG_PRIVATE_EXP: priv_exp_q <= cfg_data[WORD_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (op_q)
			OP_RED: begin
				op_a = WORD_BITS'(1);
				op_b = msg_q;
			end
			OP_MUL: begin
				op_a = base_q;
				op_b = res_q;
			end
			default: begin
				op_a = base_q;
				op_b = base_q;
			end
		endcase
	end

	assign ctl.en    = (state_q == ST_RUN);
	assign ctl.first = (cnt_q == CNT_LAST);
	assign ctl.bbit  = op_b[cnt_q];

	rsame_row #(.WORD_BITS(WORD_BITS)) u_row (
		.clk  (clk),
		.ctl  (ctl),
		.a    (op_a),
		.n    (modulus_q),
		.acc_d(acc_d)
	);

	always_comb begin
		state_d       = state_q;
		data_in.ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				data_in.ready = 1'b1;
				if (data_in.valid) begin
					state_d = small_mod ? ST_DONE : ST_RUN;
				end
			end
			ST_RUN: begin
				if (last_step && op_q == OP_SQR && bit_q == CNT_LAST) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_free) begin
				ovalid_q <= 1'b1;
			end else if (data_out.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			msg_q <= data_in.message[WORD_BITS-1:0];
			exp_q <= (data_in.mode == MODE_ENCRYPT) ? pub_exp_q : priv_exp_q;
			bit_q <= '0;
			cnt_q <= CNT_LAST;
			op_q  <= OP_RED;
			res_q <= '0;
		end else if (state_q == ST_RUN) begin
			if (last_step) begin
				cnt_q <= CNT_LAST;
				case (op_q)
					OP_RED: begin
						base_q <= acc_d;
						res_q  <= WORD_BITS'(1);
						op_q   <= exp_q[0] ? OP_MUL : OP_SQR;
					end
					OP_MUL: begin
						res_q <= acc_d;
						op_q  <= OP_SQR;
					end
					default: begin
						base_q <= acc_d;
						bit_q  <= bit_q + 1'b1;
						exp_q  <= exp_q >> 1;
						op_q   <= exp_q[1] ? OP_MUL : OP_SQR;
					end
				endcase
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
		if (state_q == ST_DONE && out_free) begin
			result_q <= res_q;
		end
	end

	assign data_out.valid        = ovalid_q;
	assign data_out.result_value = RESULT_BITS'(result_q);

endmodule

[src/rsame_checker.sv]
module rsame_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] result_value
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_value))
		else $error("result changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while busy");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared one cycle after accept");

endmodule

bind rsa_modular_exponentiation_unit rsame_checker u_rsame_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (data_in.valid),
	.in_ready    (data_in.ready),
	.out_valid   (data_out.valid),
	.out_ready   (data_out.ready),
	.result_value(data_out.result_value)
);
